>>> design/priority_multi_queue_scheduler_core_defines.svh
// Assertion macros used by the scheduler's queue bookkeeping module.
`ifndef PRIORITY_MULTI_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_MULTI_QUEUE_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMQS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmqs: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PMQS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmqs: next-cycle check failed");

`endif

>>> design/pmqs_pkg.sv
`default_nettype none

package pmqs_pkg;

   localparam int NUM_LEVELS       = 10;
   localparam int QUEUE_DEPTH      = 16;
   localparam int TAG_BITS         = 16;
   localparam int ORDER_SLOTS      = 10;
   localparam int ENTRY_BITS       = 4;
   localparam int PRIO_BITS        = 5;
   localparam int QUEUE_OUT_BITS   = 4;
   localparam int TOTAL_BITS       = 8;
   localparam int ORDER_LEN_BITS   = 4;
   localparam int ORDER_TABLE_BITS = ORDER_SLOTS * ENTRY_BITS;

   localparam int LEVEL_BITS  = $clog2(NUM_LEVELS);
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int COUNT_BITS  = $clog2(STORE_DEPTH + 1);

   localparam int REQ_DATA_BITS  = ((PRIO_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 1 + TAG_BITS + QUEUE_OUT_BITS + 1 + TOTAL_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = ORDER_TABLE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORDER_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORDER_TABLE  = CSR_INDEX_BITS'(1);

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [PTR_BITS-1:0]   ptr_type;
   typedef logic [FILL_BITS-1:0]  fill_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [TAG_BITS-1:0]   tag_type;

   // Operation on the queue bookkeeping, and the lookup of one queue.
   typedef struct packed {
      logic      push;
      logic      pop;
      level_type queue;
   } pmqs_cmd_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      ptr_type head;
      ptr_type tail;
   } pmqs_status_type;

endpackage

`default_nettype wire

>>> design/priority_multi_queue_scheduler_core.sv
`default_nettype none

// Strict-priority scheduler over NUM_LEVELS tag queues held in one synchronous RAM. A request
// word with kind 0 pushes entry_tag onto the queue of its clamped priority; kind 1 pops the
// oldest tag from the first non-empty queue in the serving order (plain order 0 upwards, or
// the configured custom order followed by queue 0). One word is handled at a time: a push
// passes through ST_PUSH and ST_FINISH before its response word is presented; a pop stays
// in ST_SCAN until a non-empty queue is found or the last order position is reached,
// visiting one order position per cycle through the single fill lookup and compare; a
// found queue gets one RAM read, whose data ST_FINISH puts into the response. The next
// request can be accepted in the same cycle as the response is presented. req_tready is
// high only while no word is in work; a finished response waits in an output register
// without holding up acceptance of the next request, but that request's response is held
// back until the register is emptied. csr_ready is always high; write the order registers
// only while the block is idle.
module priority_multi_queue_scheduler_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // entry_priority [4:0], entry_tag [20:5], zero padding above
   input  logic [pmqs_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // kind [0]
   input  logic [0:0]                             req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pop_found [0], popped_tag [16:1], popped_queue [20:17], push_dropped [21],
   // total_waiting [29:22], zero padding above
   output logic [pmqs_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pmqs_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [pmqs_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import pmqs_pkg::*;

   localparam logic KIND_POP = 1'b1;
   localparam int MAX_LEN = (NUM_LEVELS - 1 < ORDER_SLOTS) ? NUM_LEVELS - 1 : ORDER_SLOTS;
   localparam int ENTRY_CMP_BITS = ENTRY_BITS + 1;
   localparam int TOTAL_MAX = 255;

   typedef enum logic [1:0] {ST_IDLE, ST_PUSH, ST_SCAN, ST_FINISH} state_type;

   state_type state_ff, state_in;
   level_type pos_ff, pos_in;
   level_type q_ff, q_in;
   tag_type   tag_ff, tag_in;
   logic      found_ff, found_in;
   logic      dropped_ff, dropped_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff, rsp_found_in;
   tag_type   rsp_tag_ff, rsp_tag_in;
   logic [QUEUE_OUT_BITS-1:0]   rsp_queue_ff, rsp_queue_in;
   logic      rsp_dropped_ff, rsp_dropped_in;
   logic [TOTAL_BITS-1:0]       rsp_total_ff, rsp_total_in;
   logic [ORDER_LEN_BITS-1:0]   order_length_ff, order_length_in;
   logic [ORDER_TABLE_BITS-1:0] order_table_ff, order_table_in;

   logic [ORDER_LEN_BITS-1:0] active_len;
   level_type       scan_queue;
   pmqs_cmd_type    cmd;
   pmqs_status_type status;
   logic [COUNT_BITS-1:0] total;
   logic      wr_en;
   logic      rd_en;
   addr_type  wr_addr;
   addr_type  rd_addr;
   tag_type   rd_data;

   function automatic level_type clamp_level(input logic [PRIO_BITS-1:0] raw);
      if (raw[PRIO_BITS-1]) begin
         return '0;
      end else if (raw >= PRIO_BITS'(NUM_LEVELS)) begin
         return LEVEL_BITS'(NUM_LEVELS - 1);
      end
      return LEVEL_BITS'(raw);
   endfunction

   // Queue served at one position of the active order.
   function automatic level_type order_queue(input level_type pos,
                                             input logic [ORDER_LEN_BITS-1:0] len,
                                             input logic [ORDER_TABLE_BITS-1:0] tbl);
      logic [ENTRY_BITS-1:0] e;
      e = '0;
      if (len == '0) begin
         return pos;
      end
      if (ORDER_LEN_BITS'(pos) >= len) begin
         return '0;
      end
      for (int i = 0; i < ORDER_SLOTS; i++) begin
         if (ORDER_LEN_BITS'(pos) == ORDER_LEN_BITS'(i)) begin
            e = tbl[i*ENTRY_BITS +: ENTRY_BITS];
         end
      end
      // An entry that names no queue stands for queue 0.
      return ((ENTRY_CMP_BITS)'(e) < (ENTRY_CMP_BITS)'(NUM_LEVELS)) ? LEVEL_BITS'(e) : '0;
   endfunction

   function automatic addr_type store_addr(input level_type q, input ptr_type p);
      return ADDR_BITS'(ADDR_BITS'(q) * ADDR_BITS'(QUEUE_DEPTH) + ADDR_BITS'(p));
   endfunction

   assign active_len = (order_length_ff > ORDER_LEN_BITS'(MAX_LEN)) ?
                       ORDER_LEN_BITS'(MAX_LEN) : order_length_ff;
   assign scan_queue = order_queue(pos_ff, active_len, order_table_ff);

   assign wr_addr = store_addr(q_ff, status.tail);
   assign rd_addr = store_addr(scan_queue, status.head);

   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      q_in            = q_ff;
      tag_in          = tag_ff;
      found_in        = found_ff;
      dropped_in      = dropped_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_tag_in      = rsp_tag_ff;
      rsp_queue_in    = rsp_queue_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      rsp_total_in    = rsp_total_ff;
      order_length_in = order_length_ff;
      order_table_in  = order_table_ff;
      cmd             = '0;
      cmd.queue       = (state_ff == ST_SCAN) ? scan_queue : q_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_ORDER_LENGTH: begin
               order_length_in = csr_data[ORDER_LEN_BITS-1:0];
            end
            CSR_ORDER_TABLE: begin
               order_table_in = csr_data[ORDER_TABLE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               found_in   = 1'b0;
               dropped_in = 1'b0;
               if (req_tuser[0] == KIND_POP) begin
                  pos_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  q_in     = clamp_level(req_tdata[PRIO_BITS-1:0]);
                  tag_in   = req_tdata[PRIO_BITS +: TAG_BITS];
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if (status.full) begin
               dropped_in = 1'b1;
            end else begin
               cmd.push = 1'b1;
               wr_en    = 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (!status.empty) begin
               cmd.pop  = 1'b1;
               rd_en    = 1'b1;
               found_in = 1'b1;
               q_in     = scan_queue;
               state_in = ST_FINISH;
            end else if (pos_ff == LEVEL_BITS'(NUM_LEVELS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               pos_in = pos_ff + LEVEL_BITS'(1);
            end
         end
         ST_FINISH: begin
            // The response register takes the word once it is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = found_ff;
               rsp_tag_in     = found_ff ? rd_data : '0;
               rsp_queue_in   = found_ff ? QUEUE_OUT_BITS'(q_ff) : '0;
               rsp_dropped_in = dropped_ff;
               rsp_total_in   = (32'(total) > 32'(TOTAL_MAX)) ?
                                TOTAL_BITS'(TOTAL_MAX) : TOTAL_BITS'(total);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         order_length_ff <= '0;
         order_table_ff  <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         order_length_ff <= order_length_in;
         order_table_ff  <= order_table_in;
      end
      pos_ff         <= pos_in;
      q_ff           <= q_in;
      tag_ff         <= tag_in;
      found_ff       <= found_in;
      dropped_ff     <= dropped_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_queue_ff   <= rsp_queue_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_total_ff   <= rsp_total_in;
   end

   pmqs_queue_state u_queue_state (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .total  (total)
   );

   pmqs_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tag_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_total_ff, rsp_dropped_ff, rsp_queue_ff,
                                       rsp_tag_ff, rsp_found_ff});

endmodule

`default_nettype wire

>>> design/pmqs_store.sv
`default_nettype none

module pmqs_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [pmqs_pkg::ADDR_BITS-1:0] wr_addr,
   input  logic [pmqs_pkg::TAG_BITS-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [pmqs_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [pmqs_pkg::TAG_BITS-1:0]  rd_data
);
   import pmqs_pkg::*;

   // Tag store: one region of QUEUE_DEPTH slots per queue.
   tag_type mem [STORE_DEPTH];
   tag_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/pmqs_queue_state.sv
`default_nettype none
`include "priority_multi_queue_scheduler_core_defines.svh"

module pmqs_queue_state (
   input  logic                             clock,
   input  logic                             reset,
   input  pmqs_pkg::pmqs_cmd_type           cmd,
   output pmqs_pkg::pmqs_status_type        status,
   output logic [pmqs_pkg::COUNT_BITS-1:0]  total
);
   import pmqs_pkg::*;

   ptr_type  head_ff [NUM_LEVELS];
   ptr_type  head_in [NUM_LEVELS];
   ptr_type  tail_ff [NUM_LEVELS];
   ptr_type  tail_in [NUM_LEVELS];
   fill_type fill_ff [NUM_LEVELS];
   fill_type fill_in [NUM_LEVELS];
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   function automatic ptr_type next_ptr(input ptr_type p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   always_comb begin
      status = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         fill_in[i] = fill_ff[i];
         if (cmd.queue == LEVEL_BITS'(i)) begin
            status.empty = (fill_ff[i] == '0);
            status.full  = (fill_ff[i] == FILL_BITS'(QUEUE_DEPTH));
            status.head  = head_ff[i];
            status.tail  = tail_ff[i];
            if (cmd.push) begin
               tail_in[i] = next_ptr(tail_ff[i]);
               fill_in[i] = fill_ff[i] + FILL_BITS'(1);
            end else if (cmd.pop) begin
               head_in[i] = next_ptr(head_ff[i]);
               fill_in[i] = fill_ff[i] - FILL_BITS'(1);
            end
         end
      end
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         count_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            fill_ff[i] <= fill_in[i];
         end
         count_ff <= count_in;
      end
   end

   assign total = count_ff;

   `PMQS_ASSERT_IMPL(a_push_not_full, clock, reset, cmd.push, !status.full)
   `PMQS_ASSERT_IMPL(a_pop_not_empty, clock, reset, cmd.pop, !status.empty)
   `PMQS_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_BITS'(STORE_DEPTH))
   `PMQS_ASSERT_NEXT(a_push_counts, clock, reset, cmd.push, count_ff != '0)

endmodule

`default_nettype wire
